>>> src/assert_macros.svh
// Assertion helper macros for the hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication checked outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/sha_pkg.sv
// ------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha_pkg;
  typedef logic [31:0] word_t;

  // queue entry between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } item_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  function automatic word_t hash_init(input logic [2:0] i);
    case (i)
      3'd0: hash_init = 32'h6a09e667;
      3'd1: hash_init = 32'hbb67ae85;
      3'd2: hash_init = 32'h3c6ef372;
      3'd3: hash_init = 32'ha54ff53a;
      3'd4: hash_init = 32'h510e527f;
      3'd5: hash_init = 32'h9b05688c;
      3'd6: hash_init = 32'h1f83d9ab;
      default: hash_init = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

>>> src/sha_front.sv
// ------------------------------------------------------------------------
// SHA-256 front end
// Accepts stream items, drops empty non-final ones, queues the rest.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // byte_present
  input  logic       in_tlast,   // last
  output logic       q_valid,
  input  logic       q_pop,
  output item_t      q_item
);
  item_t           mem_r [QDepth];
  logic [QAw-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAw:0]    cnt_r, cnt_nxt;
  logic            push;

  assign in_tready = (cnt_r != (QAw+1)'(QDepth));
  // drop items that carry neither a byte nor an end mark
  assign push    = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAw+1)'(push) - (QAw+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{data_byte: in_tdata, byte_present: in_tuser, last: in_tlast};
  end
endmodule

>>> src/sha_back.sv
// ------------------------------------------------------------------------
// SHA-256 back end
// Fills blocks, pads, runs one compression round per cycle, emits digest.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast,  // last_word
  output logic        busy
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2,
                         S_RND = 3'd3, S_ADD = 3'd4, S_OUT = 3'd5;

  logic [2:0]  st_r, st_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];    // block words, then the rolling schedule window
  logic [63:0] bits_r;
  logic [5:0]  pidx_r;      // pad write index
  logic        marked_r;    // 0x80 already written
  logic        lenblk_r;    // current pad block carries the bit count
  logic        fin_r;       // finishing message after this compression
  logic        pad_r;       // another pad block follows this compression
  logic [5:0]  t_r;
  logic [2:0]  oi_r;

  word_t w15, w2, wnew, wt, s0, s1, mj, ch, t1, t2;
  logic [5:0] fill, pstart;
  logic [7:0] pbyte;
  logic       full_byte;

  assign fill      = bits_r[8:3];
  assign full_byte = q_item.byte_present && (fill == 6'd63);
  // marker position; wraps to 0 when the byte completes the block
  assign pstart    = fill + 6'(q_item.byte_present);
  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign busy      = (st_r != S_IDLE);

  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {5'd0, oi_r, h_r[oi_r]};
  assign out_tlast  = (oi_r == 3'd7);

  always_comb begin
    if (!marked_r) pbyte = 8'h80;
    else if (lenblk_r && pidx_r >= 6'd56)
      pbyte = 8'(bits_r >> {3'd7 - pidx_r[2:0], 3'd0});
    else pbyte = 8'h00;
  end

  always_comb begin
    w15  = w_r[4'(t_r - 6'd15)];
    w2   = w_r[4'(t_r - 6'd2)];
    wnew = w_r[t_r[3:0]] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
         + w_r[4'(t_r - 6'd7)] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
    wt   = (t_r < 6'd16) ? w_r[t_r[3:0]] : wnew;
    s0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = s0 + mj;
    s1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + s1 + ch + round_k(t_r) + wt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        if (full_byte) st_nxt = S_LOAD;
        else if (q_item.last) st_nxt = S_PAD;
      end
      S_PAD:  if (pidx_r == 6'd63) st_nxt = S_LOAD;
      S_LOAD: st_nxt = S_RND;
      S_RND:  if (t_r == 6'd63) st_nxt = S_ADD;
      S_ADD:  st_nxt = fin_r ? S_OUT : (pad_r ? S_PAD : S_IDLE);
      S_OUT:  if (out_tready && oi_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      bits_r <= '0;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      oi_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= hash_init(3'(i));
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (q_valid) begin
          if (q_item.byte_present) bits_r <= bits_r + 64'd8;
          fin_r <= 1'b0;
          // a final byte that fills the block defers padding to after compression
          pad_r <= full_byte && q_item.last;
        end
        S_PAD: if (pidx_r == 6'd63) begin
          fin_r <= lenblk_r;
          pad_r <= !lenblk_r;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        S_OUT: if (out_tready) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            bits_r <= '0;
            for (int i = 0; i < 8; i++) h_r[i] <= hash_init(3'(i));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (q_valid) begin
        if (q_item.byte_present)
          w_r[fill[5:2]][{~fill[1:0], 3'd0} +: 8] <= q_item.data_byte;
        pidx_r   <= pstart;
        marked_r <= 1'b0;
        lenblk_r <= (pstart < 6'd56);
      end
      S_PAD: begin
        w_r[pidx_r[5:2]][{~pidx_r[1:0], 3'd0} +: 8] <= pbyte;
        pidx_r   <= pidx_r + 6'd1;
        marked_r <= 1'b1;
        // a following pad block always has room for the bit count
        if (pidx_r == 6'd63) lenblk_r <= 1'b1;
      end
      S_LOAD: begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        t_r <= '0;
      end
      S_RND: begin
        if (t_r >= 6'd16) w_r[t_r[3:0]] <= wnew;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        t_r <= t_r + 6'd1;
      end
      default: ;
    endcase
  end
endmodule

>>> src/sha256_stream_hasher.sv
// ------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with queued front end and round-per-cycle core.
// ------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per item; in_tuser marks a present byte,
//           in_tlast ends the message (may carry no byte).
//   out_* : eight digest words, word 0 first; out_tlast on word 7.
// Bytes go straight into the sixteen block words. A byte that completes
// a 64-byte block makes the core take it, load, run the rounds and add,
// all through the single round unit.
// Padding writes one byte per cycle from the marker to the block end.
// After a final item is accepted, the core compresses the completed
// block, if any, and one or two pad blocks, then emits the digest
// words. Items run one after another, not overlapped.
// A four-entry queue decouples the input from the core.
// Reset (rst_n low, synchronous) restores the initial hash and clears
// the bit count. A stalled receiver holds the current digest word and
// the core, while the queue keeps taking items until full.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast   // last_word
);
  logic  q_valid, q_pop, busy;
  item_t q_item;

  sha_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
                     .in_tlast, .q_valid, .q_pop, .q_item);
  sha_back  u_back  (.clk, .rst_n, .q_valid, .q_pop, .q_item, .out_tvalid,
                     .out_tready, .out_tdata, .out_tlast, .busy);

  `ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, !busy && q_valid)
  `ASSERT_IMP(a_last_idx, clk, rst_n, out_tvalid && out_tlast, out_tdata[34:32] == 3'd7)
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

>>> tb/sv/sha256_checker.sv
// ------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Watches both channels, runs its own SHA-256 on each accepted item and
// compares every digest word against the oldest predicted word.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  input  logic        out_tlast,  // last_word
  output int          fail_count,
  output int          words_pending,
  output int          digests_seen
);
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lastw;
  } digest_word_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + KTAB[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void absorb_item(input logic [7:0] data, input logic present,
                                      input logic fin);
    int fill;
    logic [63:0] total;
    digest_word_t dw;
    if (present) begin
      fill = int'(msg_bits[8:3]);
      blk[fill] = data;
      msg_bits += 64'd8;
      if (fill == 63) compress_blk();
    end
    if (!fin) return;
    total = msg_bits;
    fill = int'(total[8:3]);
    blk[fill] = 8'h80;
    fill++;
    // no room for the length: flush an extra block first
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 8'h00;
      compress_blk();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      dw.word  = chain[i];
      dw.idx   = 3'(i);
      dw.lastw = (i == 7);
      digest_q.push_back(dw);
    end
    chain = IV;
    msg_bits = '0;
  endfunction

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      chain = IV;
      msg_bits = '0;
      digest_q.delete();
      fail_count <= 0;
      digests_seen <= 0;
    end else begin
      if (in_tvalid && in_tready) absorb_item(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_tdata[31:0]);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_tdata[31:0] !== exp_w.word ||
              out_tdata[34:32] !== exp_w.idx || out_tlast !== exp_w.lastw) begin
            if (out_tdata[31:0] !== exp_w.word)
              $error("digest_word: expected %h, got %h", exp_w.word, out_tdata[31:0]);
            if (out_tdata[34:32] !== exp_w.idx)
              $error("word_index: expected %0d, got %0d", exp_w.idx, out_tdata[34:32]);
            if (out_tlast !== exp_w.lastw)
              $error("last_word: expected %0b, got %0b", exp_w.lastw, out_tlast);
            fail_count <= fail_count + 1;
          end
          if (exp_w.lastw) digests_seen <= digests_seen + 1;
        end
      end
    end
    words_pending <= digest_q.size();
  end
endmodule

>>> tb/sv/testbench.sv
// ------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams directed and random messages through the hasher under three
// handshake pressure phases; the checker predicts and compares digests.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // byte_present
  logic        in_tlast = 1'b0; // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] digest_word, [34:32] word_index
  logic        out_tlast;       // last_word
  int          fail_count, words_pending, digests_seen;
  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          cycles = 0, items_sent = 0;

  always #2 clk = ~clk;

  sha256_stream_hasher i_dut (.*);

  sha256_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(negedge clk)
    if (rst_n) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // send a message of len random or fixed bytes; the last byte may ride on tlast
  task automatic send_msg(input int len, input bit rand_bytes, input logic [7:0] fixed);
    bit on_last;
    on_last = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(rand_bytes ? 8'($urandom) : fixed, 1'b1, on_last && i == len - 1);
    end
    if (!on_last) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 79 : 0;
      rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 25 : 0;
      if (phase == 0) begin
        // empty message, extreme byte values, empty non-final items, a short message
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_msg(3, 1'b1, 8'h00);
      end
      while (items_sent < 140 * (phase + 1)) begin
        case ($urandom_range(9))
          0: len = 55 + $urandom_range(10);
          1: len = 119 + $urandom_range(10);
          2: len = 0;
          default: len = $urandom_range(40);
        endcase
        send_msg(len, $urandom_range(7) != 0, $urandom_range(1) ? 8'hFF : 8'h00);
      end
    end
    in_tvalid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d items, checked %0d digests over three pressure phases",
             items_sent, digests_seen);
    if (fail_count == 0 && words_pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/sha_pkg.sv
src/sha_front.sv
src/sha_back.sv
src/sha256_stream_hasher.sv
tb/sv/sha256_checker.sv
tb/sv/testbench.sv
